// File: hw/rtl/selective_repeat_receiver_unit_macros.svh
// ----------------------------------------------------------------------------
// selective repeat receiver assertion macros
// shared property forms for the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_UNIT_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define SRR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/srr_pkg.sv
// ----------------------------------------------------------------------------
// srr_pkg
// shared types, codes and constants of the selective repeat receiver
// ----------------------------------------------------------------------------
package srr_pkg;

  // default bitmap depth and largest legal payload
  localparam int MAX_PACKETS_DEF = 1024;
  localparam int PAYLOAD_BYTES   = 2048;

  // header field widths
  localparam int SEQ_W   = 10;
  localparam int BYTES_W = 11;
  localparam int EXP_W   = 11;
  localparam int SUM_W   = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    VERDICT_CORRUPT  = 3'd0,
    VERDICT_NAME     = 3'd1,
    VERDICT_IN_ORDER = 3'd2,
    VERDICT_STORED   = 3'd3,
    VERDICT_DUP      = 3'd4,
    VERDICT_RELEASED = 3'd5,
    VERDICT_NOTHING  = 3'd6
  } verdict_t;

  typedef enum logic {
    REQ_BYTE  = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  // one classified command: a finished packet or a drain request
  typedef struct packed {
    req_t               req;
    logic               corrupt;
    logic [SEQ_W-1:0]   seq;
    logic [BYTES_W-1:0] bytes;
    logic [SEQ_W-1:0]   total;
  } cmd_t;

endpackage

// File: hw/rtl/srr_ram.sv
// ----------------------------------------------------------------------------
// srr_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/srr_front.sv
// ----------------------------------------------------------------------------
// srr_front
// takes input transfers, folds payload bytes into the checksum and turns
// packet ends and drain requests into commands for the back end
// ----------------------------------------------------------------------------
module srr_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [srr_pkg::SEQ_W-1:0]   seq_number,
  input  logic [srr_pkg::BYTES_W-1:0] byte_count,
  input  logic [srr_pkg::SEQ_W-1:0]   total_count,
  input  logic signed [31:0]          sent_checksum,
  input  logic signed [7:0]           payload_byte,
  input  logic                        last_byte,
  input  logic                        q_full,
  input  logic                        clear_busy,
  output logic                        push,
  output srr_pkg::cmd_t               push_cmd
);
  import srr_pkg::*;

  logic             accept;
  logic [SUM_W-1:0] running_xor;
  logic [SUM_W-1:0] running_xor_next;
  logic [SUM_W-1:0] folded;
  logic [SUM_W-1:0] sum;
  logic             oversize;

  // no transfer while the queue is full or the bitmap is being cleared
  assign in_stall = q_full | clear_busy;
  assign accept   = in_valid & ~in_stall;

  // checksum of the packet so far including this byte
  always_comb begin
    folded   = running_xor ^ ((byte_count != '0) ? SUM_W'(payload_byte) : '0);
    sum      = folded ^ SUM_W'(seq_number) ^ SUM_W'(byte_count) ^ SUM_W'(total_count);
    oversize = 32'(byte_count) > 32'(PAYLOAD_BYTES);
  end

  // running checksum, restarts after every last byte
  always_comb begin
    running_xor_next = running_xor;
    if (accept && req_type == REQ_BYTE) begin
      running_xor_next = last_byte ? '0 : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor <= '0;
    end else begin
      running_xor <= running_xor_next;
    end
  end

  // command out on packet end or drain
  assign push = accept & ((req_type == REQ_DRAIN) | last_byte);

  always_comb begin
    push_cmd.req     = req_t'(req_type);
    push_cmd.corrupt = (sum != $unsigned(sent_checksum)) | oversize;
    push_cmd.seq     = seq_number;
    push_cmd.bytes   = byte_count;
    push_cmd.total   = total_count;
  end

endmodule

// File: hw/rtl/srr_queue.sv
// ----------------------------------------------------------------------------
// srr_queue
// short command queue that decouples the front from the back end
// ----------------------------------------------------------------------------
module srr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  srr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output srr_pkg::cmd_t head
);
  import srr_pkg::*;

  cmd_t           entry [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full    = (count == QCW'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = entry[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/srr_back.sv
// ----------------------------------------------------------------------------
// srr_back
// carries out commands: bitmap read-modify-write, sequence tracking and the
// output register; clears the bitmap after reset
// ----------------------------------------------------------------------------
module srr_back #(
  parameter int MAX_PACKETS = srr_pkg::MAX_PACKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  srr_pkg::cmd_t               head,
  output logic                        pop,
  output logic                        clear_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  verdict,
  output logic                        send_ack,
  output logic [srr_pkg::SEQ_W-1:0]   ack_seq,
  output logic [srr_pkg::BYTES_W-1:0] ack_bytes,
  output logic                        transfer_done
);
  import srr_pkg::*;

  localparam int AW = $clog2(MAX_PACKETS);

  // clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // execute stage
  logic b_valid;
  cmd_t b_cmd;
  logic b_fire;
  logic fwd_hit;
  logic fwd_bit;

  // receiver state
  logic [EXP_W-1:0] expected_seq;
  logic [EXP_W-1:0] total_packets;
  logic             done_flag;

  // decision
  logic [EXP_W-1:0]   exp_next;
  logic [EXP_W-1:0]   total_next;
  logic               done_next;
  logic [EXP_W-1:0]   exp_inc;
  logic [EXP_W-1:0]   exp_after;
  logic [31:0]        seq_wide;
  logic [31:0]        exp_wide;
  logic [31:0]        after_wide;
  logic [31:0]        head_wide;
  logic               seq_in_map;
  logic               exp_in_map;
  logic               map_bit;
  logic               map_we;
  logic [AW-1:0]      map_addr;
  logic               map_wdata;
  verdict_t           dec_verdict;
  logic               dec_ack;
  logic [SEQ_W-1:0]   dec_seq;
  logic [BYTES_W-1:0] dec_bytes;

  // memory ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [0:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [0:0]    ram_rdata;

  assign clear_busy = clr_busy;

  // handshake between queue, execute stage and output register
  assign b_fire = b_valid & (~out_valid | ~out_stall);
  assign pop    = q_valid & (~b_valid | ~out_valid | ~out_stall) & ~clr_busy;

  // index forms of the sequence numbers
  always_comb begin
    seq_wide   = 32'(b_cmd.seq);
    exp_wide   = 32'(expected_seq);
    seq_in_map = seq_wide < 32'(MAX_PACKETS);
    exp_in_map = exp_wide < 32'(MAX_PACKETS);
    exp_inc    = expected_seq + 1'b1;
    map_bit    = fwd_hit ? fwd_bit : ram_rdata[0];
  end

  // verdict and next state for the command in the execute stage
  always_comb begin
    dec_verdict = VERDICT_NOTHING;
    dec_ack     = 1'b0;
    dec_seq     = '0;
    dec_bytes   = '0;
    exp_next    = expected_seq;
    total_next  = total_packets;
    done_next   = done_flag;
    map_we      = 1'b0;
    map_addr    = seq_wide[AW-1:0];
    map_wdata   = 1'b0;
    if (b_cmd.req == REQ_DRAIN) begin
      if (!done_flag && expected_seq != '0 && exp_in_map && map_bit) begin
        dec_verdict = VERDICT_RELEASED;
        dec_seq     = expected_seq[SEQ_W-1:0];
        map_we      = 1'b1;
        map_addr    = exp_wide[AW-1:0];
        exp_next    = exp_inc;
        done_next   = done_flag | (exp_inc > total_packets);
      end
    end else begin
      dec_seq   = b_cmd.seq;
      dec_bytes = b_cmd.bytes;
      if (b_cmd.corrupt) begin
        dec_verdict = VERDICT_CORRUPT;
      end else if (done_flag) begin
        dec_verdict = VERDICT_DUP;
        dec_ack     = 1'b1;
      end else if (b_cmd.seq == '0) begin
        dec_ack = 1'b1;
        if (expected_seq == '0) begin
          dec_verdict = VERDICT_NAME;
          total_next  = EXP_W'(b_cmd.total);
          exp_next    = EXP_W'(1);
          done_next   = EXP_W'(1) > EXP_W'(b_cmd.total);
        end else begin
          dec_verdict = VERDICT_DUP;
        end
      end else if (EXP_W'(b_cmd.seq) == expected_seq) begin
        dec_verdict = VERDICT_IN_ORDER;
        dec_ack     = 1'b1;
        map_we      = seq_in_map;
        exp_next    = exp_inc;
        done_next   = done_flag | (exp_inc > total_packets);
      end else if (EXP_W'(b_cmd.seq) < expected_seq) begin
        dec_verdict = VERDICT_DUP;
        dec_ack     = 1'b1;
      end else if (!seq_in_map || map_bit) begin
        dec_verdict = VERDICT_DUP;
      end else begin
        dec_verdict = VERDICT_STORED;
        dec_ack     = 1'b1;
        map_we      = 1'b1;
        map_wdata   = 1'b1;
      end
    end
  end

  // read address for the command entering the execute stage
  always_comb begin
    exp_after  = b_fire ? exp_next : expected_seq;
    after_wide = 32'(exp_after);
    head_wide  = 32'(head.seq);
    ram_raddr  = (head.req == REQ_DRAIN) ? after_wide[AW-1:0] : head_wide[AW-1:0];
  end

  // write port shared by the clearing pass and the execute stage
  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = b_fire & map_we;
      ram_waddr = map_addr;
      ram_wdata = map_wdata;
    end
  end

  srr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_PACKETS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clearing pass over the bitmap after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(MAX_PACKETS - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // execute stage and bypass of a write to the address being read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cmd   <= head;
      fwd_hit <= b_fire & map_we & (map_addr == ram_raddr);
      fwd_bit <= map_wdata;
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq  <= '0;
      total_packets <= EXP_W'(MAX_PACKETS - 1);
      done_flag     <= 1'b0;
    end else if (b_fire) begin
      expected_seq  <= exp_next;
      total_packets <= total_next;
      done_flag     <= done_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      verdict       <= dec_verdict;
      send_ack      <= dec_ack;
      ack_seq       <= dec_seq;
      ack_bytes     <= dec_bytes;
      transfer_done <= done_next;
    end
  end

endmodule

// File: hw/rtl/selective_repeat_receiver_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// selective repeat receiver control: checksum, verdicts and in-order release
// ----------------------------------------------------------------------------
// The unit takes one input transfer per cycle while in_stall is low: payload
// bytes of a packet, with the header repeated on each, or drain requests.
// Bytes that are not the last of a packet give no result. A last byte or a
// drain gives exactly one result, taken through a registered output after
// the command queue and the execute stage; it comes later while the output
// stalls. Packet ends and drains pass through a two-entry command queue to a
// back end that retires one command per cycle while the output does not
// stall, doing a read-modify-write of the MAX_PACKETS-entry out-of-order
// bitmap memory. After reset the input stalls while that bitmap is cleared.
module selective_repeat_receiver_unit #(
  parameter int MAX_PACKETS = srr_pkg::MAX_PACKETS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [srr_pkg::SEQ_W-1:0]   seq_number,
  input  logic [srr_pkg::BYTES_W-1:0] byte_count,
  input  logic [srr_pkg::SEQ_W-1:0]   total_count,
  input  logic signed [31:0]          sent_checksum,
  input  logic signed [7:0]           payload_byte,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  verdict,
  output logic                        send_ack,
  output logic [srr_pkg::SEQ_W-1:0]   ack_seq,
  output logic [srr_pkg::BYTES_W-1:0] ack_bytes,
  output logic                        transfer_done
);
  import srr_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic pop;
  cmd_t head;
  logic clear_busy;

  // front: accept and classify
  srr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .seq_number    (seq_number),
    .byte_count    (byte_count),
    .total_count   (total_count),
    .sent_checksum (sent_checksum),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .q_full        (q_full),
    .clear_busy    (clear_busy),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  // command queue
  srr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  // back end: bitmap, sequence state and results
  srr_back #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .clear_busy    (clear_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .send_ack      (send_ack),
    .ack_seq       (ack_seq),
    .ack_bytes     (ack_bytes),
    .transfer_done (transfer_done)
  );

endmodule

// File: hw/rtl/srr_checker.sv
// ----------------------------------------------------------------------------
// srr_checker
// port-level checks on the receiver results, bound to the top level
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_unit_macros.svh"

module srr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [2:0]                  verdict,
  input logic                        send_ack,
  input logic [srr_pkg::SEQ_W-1:0]   ack_seq,
  input logic [srr_pkg::BYTES_W-1:0] ack_bytes,
  input logic                        transfer_done
);
  import srr_pkg::*;

  // a stalled result holds
  `SRR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict) && $stable(ack_seq) && $stable(ack_bytes), "stalled result changed")

  // no ack on corrupt, released or empty drain results
  `SRR_ASSERT_SAME(a_no_ack, out_valid && (verdict == VERDICT_CORRUPT || verdict == VERDICT_RELEASED || verdict == VERDICT_NOTHING), !send_ack, "ack on a verdict that carries none")

  // an empty drain carries zero fields
  `SRR_ASSERT_SAME(a_nothing_zero, out_valid && verdict == VERDICT_NOTHING, ack_seq == '0 && ack_bytes == '0, "empty drain with nonzero fields")

  // a release names a real packet and echoes no bytes
  `SRR_ASSERT_SAME(a_release_fields, out_valid && verdict == VERDICT_RELEASED, ack_seq != '0 && ack_bytes == '0, "bad released fields")

  // completion is sticky across back-to-back results
  `SRR_ASSERT_NEXT(a_done_sticky, out_valid && !out_stall && transfer_done, !out_valid || transfer_done, "transfer done dropped")

endmodule

bind selective_repeat_receiver_unit srr_checker u_srr_checker (.*);

// File: sim/srr_result_checker.sv
// ----------------------------------------------------------------------------
// srr_result_checker
// watches both channels of the selective repeat receiver, predicts the
// verdict of every packet end and drain request, and compares each result
// transfer field by field with the oldest prediction still waiting
// ----------------------------------------------------------------------------
module srr_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        req_type,
  input  logic [srr_pkg::SEQ_W-1:0]   seq_number,
  input  logic [srr_pkg::BYTES_W-1:0] byte_count,
  input  logic [srr_pkg::SEQ_W-1:0]   total_count,
  input  logic signed [31:0]          sent_checksum,
  input  logic signed [7:0]           payload_byte,
  input  logic                        last_byte,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [2:0]                  verdict,
  input  logic                        send_ack,
  input  logic [srr_pkg::SEQ_W-1:0]   ack_seq,
  input  logic [srr_pkg::BYTES_W-1:0] ack_bytes,
  input  logic                        transfer_done,
  output int                          fail_count,
  output int                          pending,
  output logic [srr_pkg::EXP_W-1:0]   next_seq,
  output logic                        all_delivered
);
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;

  typedef struct {
    verdict_t           verdict;
    logic               ack;
    logic [SEQ_W-1:0]   seq;
    logic [BYTES_W-1:0] bytes;
    logic               done;
  } ack_result_t;

  ack_result_t        verdicts_due[$];
  ack_result_t        due_r;

  // receiver state as predicted
  logic [EXP_W-1:0]   next_in_order;
  logic [EXP_W-1:0]   last_seq_of_xfer;
  bit                 held_map [MAX_PACKETS_DEF];
  logic [SUM_W-1:0]   pkt_xor;
  logic [SUM_W-1:0]   pkt_sum;
  logic               xfer_done;
  logic [SEQ_W-1:0]   rel_seq;
  int                 shown;

  // transfer counts as complete once the next number passes the last one
  function void note_progress();
    if (next_in_order > last_seq_of_xfer) xfer_done = 1'b1;
  endfunction

  function void queue_verdict(verdict_t v, logic ack, logic [SEQ_W-1:0] s,
                              logic [BYTES_W-1:0] b);
    ack_result_t r;
    r.verdict = v;
    r.ack     = ack;
    r.seq     = s;
    r.bytes   = b;
    r.done    = xfer_done;
    verdicts_due.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      verdicts_due.delete();
      next_in_order    = '0;
      last_seq_of_xfer = EXP_W'(MAX_PACKETS_DEF - 1);
      foreach (held_map[i]) held_map[i] = 1'b0;
      pkt_xor          = '0;
      xfer_done        = 1'b0;
      shown            = 0;
      fail_count    <= 0;
      pending       <= 0;
      next_seq      <= '0;
      all_delivered <= 1'b0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10)
            $display("%0t: result with none due: verdict %0d ack %0d seq %0d bytes %0d done %0d",
                     $realtime, verdict, send_ack, ack_seq, ack_bytes, transfer_done);
          shown++;
        end else begin
          due_r = verdicts_due.pop_front();
          if (verdict !== due_r.verdict || send_ack !== due_r.ack ||
              ack_seq !== due_r.seq || ack_bytes !== due_r.bytes ||
              transfer_done !== due_r.done) begin
            fail_count <= fail_count + 1;
            if (shown < 10)
              $display("%0t: mismatch: expected verdict %0d ack %0d seq %0d bytes %0d done %0d, %s",
                       $realtime, due_r.verdict, due_r.ack, due_r.seq, due_r.bytes,
                       due_r.done,
                       $sformatf("got verdict %0d ack %0d seq %0d bytes %0d done %0d",
                                 verdict, send_ack, ack_seq, ack_bytes, transfer_done));
            shown++;
          end
        end
      end

      // verdict of each input transfer
      if (in_valid && !in_stall) begin
        if (req_type == REQ_DRAIN) begin
          // release the next held packet, if it is the one in sequence
          if (!xfer_done && next_in_order != '0 && next_in_order < MAX_PACKETS_DEF &&
              held_map[next_in_order[SEQ_W-1:0]]) begin
            rel_seq           = next_in_order[SEQ_W-1:0];
            held_map[rel_seq] = 1'b0;
            next_in_order     = next_in_order + 1'b1;
            note_progress();
            queue_verdict(VERDICT_RELEASED, 1'b0, rel_seq, '0);
          end else begin
            queue_verdict(VERDICT_NOTHING, 1'b0, '0, '0);
          end
        end else begin
          // bytes of an empty packet stay out of the checksum
          if (byte_count != '0) pkt_xor ^= {{24{payload_byte[7]}}, payload_byte};
          if (last_byte) begin
            pkt_sum = pkt_xor ^ SUM_W'(seq_number) ^ SUM_W'(byte_count) ^
                      SUM_W'(total_count);
            pkt_xor = '0;
            if (pkt_sum != sent_checksum || int'(byte_count) > PAYLOAD_BYTES) begin
              queue_verdict(VERDICT_CORRUPT, 1'b0, seq_number, byte_count);
            end else if (xfer_done) begin
              queue_verdict(VERDICT_DUP, 1'b1, seq_number, byte_count);
            end else if (seq_number == '0) begin
              // name packet sets the last number only the first time
              if (next_in_order == '0) begin
                last_seq_of_xfer = EXP_W'(total_count);
                next_in_order    = EXP_W'(1);
                note_progress();
                queue_verdict(VERDICT_NAME, 1'b1, seq_number, byte_count);
              end else begin
                queue_verdict(VERDICT_DUP, 1'b1, seq_number, byte_count);
              end
            end else if (EXP_W'(seq_number) == next_in_order) begin
              held_map[seq_number] = 1'b0;
              next_in_order        = next_in_order + 1'b1;
              note_progress();
              queue_verdict(VERDICT_IN_ORDER, 1'b1, seq_number, byte_count);
            end else if (EXP_W'(seq_number) < next_in_order) begin
              queue_verdict(VERDICT_DUP, 1'b1, seq_number, byte_count);
            end else if (int'(seq_number) >= MAX_PACKETS_DEF || held_map[seq_number]) begin
              queue_verdict(VERDICT_DUP, 1'b0, seq_number, byte_count);
            end else begin
              held_map[seq_number] = 1'b1;
              queue_verdict(VERDICT_STORED, 1'b1, seq_number, byte_count);
            end
          end
        end
      end

      pending       <= verdicts_due.size();
      next_seq      <= next_in_order;
      all_delivered <= xfer_done;
    end
  end

endmodule

// File: sim/tb_selective_repeat_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_selective_repeat_receiver_unit
// drives packets and drain requests into the selective repeat receiver under
// changing sender and receiver back-pressure, leaves checking to the checker
// and reports the outcome
// ----------------------------------------------------------------------------
module tb_selective_repeat_receiver_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;

  localparam int              QUIET_LIMIT  = 4000;
  localparam int              ITEM_TARGET  = 975;
  localparam logic [SEQ_W-1:0] XFER_LAST   = 10'd120;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic               req_type      = 1'b0;
  logic [SEQ_W-1:0]   seq_number    = '0;
  logic [BYTES_W-1:0] byte_count    = '0;
  logic [SEQ_W-1:0]   total_count   = '0;
  logic signed [31:0] sent_checksum = '0;
  logic signed [7:0]  payload_byte  = '0;
  logic               last_byte     = 1'b0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [2:0]         verdict;
  logic               send_ack;
  logic [SEQ_W-1:0]   ack_seq;
  logic [BYTES_W-1:0] ack_bytes;
  logic               transfer_done;

  int                 fail_count;
  int                 pending;
  logic [EXP_W-1:0]   next_seq;
  logic               all_delivered;

  // stimulus bookkeeping
  int                 items_sent    = 0;
  int                 stall_pct     = 0;
  int                 quiet_cycles  = 0;
  int                 idle_pct_of[4]  = '{0, 56, 0, 16};
  int                 stall_pct_of[4] = '{0, 0, 56, 16};
  bit                 pkt_sent_ok [MAX_PACKETS_DEF];
  int                 win_base      = 1;
  int                 pick;
  logic [SEQ_W-1:0]   s_pick;
  logic [BYTES_W-1:0] b_pick;
  logic [SEQ_W-1:0]   t_pick;

  always #6 clk = ~clk;

  selective_repeat_receiver_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .seq_number    (seq_number),
    .byte_count    (byte_count),
    .total_count   (total_count),
    .sent_checksum (sent_checksum),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .send_ack      (send_ack),
    .ack_seq       (ack_seq),
    .ack_bytes     (ack_bytes),
    .transfer_done (transfer_done)
  );

  srr_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .seq_number    (seq_number),
    .byte_count    (byte_count),
    .total_count   (total_count),
    .sent_checksum (sent_checksum),
    .payload_byte  (payload_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .verdict       (verdict),
    .send_ack      (send_ack),
    .ack_seq       (ack_seq),
    .ack_bytes     (ack_bytes),
    .transfer_done (transfer_done),
    .fail_count    (fail_count),
    .pending       (pending),
    .next_seq      (next_seq),
    .all_delivered (all_delivered)
  );

  // receiver back-pressure at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("selective_repeat_receiver_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one input transfer, with idle gaps set by the current phase
  task automatic send_item(input req_t rq, input logic [SEQ_W-1:0] s,
                           input logic [BYTES_W-1:0] b, input logic [SEQ_W-1:0] t,
                           input logic [31:0] sum, input logic [7:0] pb,
                           input logic lst);
    int ph;
    ph = (items_sent / 64) % 4;
    stall_pct <= stall_pct_of[ph];
    while ($urandom_range(99) < idle_pct_of[ph]) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= rq;
    seq_number    <= s;
    byte_count    <= b;
    total_count   <= t;
    sent_checksum <= sum;
    payload_byte  <= pb;
    last_byte     <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_drain();
    send_item(REQ_DRAIN, 10'($urandom), 11'($urandom), 10'($urandom), $urandom,
              8'($urandom), 1'($urandom));
  endtask

  // a whole packet with a checksum that matches its header, unless spoilt
  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic [BYTES_W-1:0] b,
                             input logic [SEQ_W-1:0] t, input int n_items,
                             input bit spoil);
    logic [7:0]  body [8];
    logic [31:0] sum;
    sum = 32'(s) ^ 32'(b) ^ 32'(t);
    for (int i = 0; i < n_items; i++) begin
      body[i] = 8'($urandom);
      if (b != '0) sum ^= {{24{body[i][7]}}, body[i]};
    end
    if (spoil) sum ^= 32'd1 << $urandom_range(31);
    for (int i = 0; i < n_items; i++)
      send_item(REQ_BYTE, s, b, t, sum, body[i], i == n_items - 1);
    if (!spoil && s != '0) begin
      pkt_sent_ok[s] = 1'b1;
      while (win_base < MAX_PACKETS_DEF - 1 && pkt_sent_ok[win_base]) win_base++;
    end
  endtask

  // hold the sender until every predicted result has been taken
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // drain with nothing held
    send_drain();
    // empty packet ahead of the name packet: payload ignored, held
    send_packet(10'd5, 11'd0, 10'd37, 1, 1'b0);
    // largest sequence and byte count, byte extremes, held
    send_item(REQ_BYTE, 10'd1023, 11'd2047, 10'd1023,
              32'hffff_ff80 ^ 32'h7f ^ 32'd1023 ^ 32'd2047 ^ 32'd1023, 8'h80, 1'b0);
    send_item(REQ_BYTE, 10'd1023, 11'd2047, 10'd1023,
              32'hffff_ff80 ^ 32'h7f ^ 32'd1023 ^ 32'd2047 ^ 32'd1023, 8'h7f, 1'b1);
    // already held
    send_packet(10'd5, 11'd3, 10'd37, 2, 1'b0);
    // bad checksum
    send_packet(10'd2, 11'd9, 10'd0, 2, 1'b1);
    // checksum word extremes
    send_item(REQ_BYTE, 10'd6, 11'd1, 10'd1, 32'h8000_0000, 8'h00, 1'b1);
    send_item(REQ_BYTE, 10'd6, 11'd1, 10'd1, 32'h7fff_ffff, 8'h00, 1'b1);
    // name packet, then a repeat of it
    send_packet(10'd0, 11'd16, XFER_LAST, 3, 1'b0);
    send_packet(10'd0, 11'd4, 10'd999, 1, 1'b0);
    // in order, then stale
    send_packet(10'd1, 11'd7, XFER_LAST, 2, 1'b0);
    send_packet(10'd1, 11'd7, XFER_LAST, 1, 1'b0);
    // out of order, gap filled, releases
    send_packet(10'd3, 11'd20, XFER_LAST, 1, 1'b0);
    send_drain();
    send_packet(10'd2, 11'd1, XFER_LAST, 1, 1'b0);
    send_drain();
    send_drain();
    send_packet(10'd4, 11'd0, XFER_LAST, 1, 1'b0);
    send_drain();

    // random traffic: mostly packets around the window, some noise and drains
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        send_drain();
      end else if (pick < 24) begin
        send_item(req_t'($urandom_range(1)), 10'($urandom), 11'($urandom),
                  10'($urandom), $urandom, 8'($urandom), $urandom_range(3) != 0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 76)
          s_pick = (win_base + 6 > MAX_PACKETS_DEF - 1) ? 10'd1023 :
                   10'(win_base + $urandom_range(6));
        else if (pick < 88)
          s_pick = (win_base > 1) ? 10'($urandom_range(win_base - 1)) : 10'd0;
        else
          s_pick = 10'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 6)       b_pick = '0;
        else if (pick < 90) b_pick = 11'($urandom_range(64));
        else                b_pick = 11'($urandom_range(2047));
        t_pick = $urandom_range(1) ? XFER_LAST : 10'($urandom_range(1023));
        send_packet(s_pick, b_pick, t_pick, $urandom_range(1, 6), $urandom_range(99) < 10);
      end
    end

    // bring the transfer to its end in sequence order
    forever begin
      wait_results_drained();
      if (all_delivered) break;
      send_packet(next_seq[SEQ_W-1:0], 11'($urandom_range(64)), XFER_LAST,
                  $urandom_range(1, 3), 1'b0);
    end

    // after completion: acked duplicate, idle drain, still corrupt
    send_packet(10'd7, 11'd2, XFER_LAST, 2, 1'b0);
    send_drain();
    send_packet(10'd8, 11'd5, XFER_LAST, 1, 1'b1);

    wait_results_drained();
    repeat (24) @(posedge clk);
    if (fail_count == 0) begin
      $display("selective_repeat_receiver_unit verification clean");
    end else begin
      $display("selective_repeat_receiver_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/srr_pkg.sv
hw/rtl/srr_ram.sv
hw/rtl/srr_front.sv
hw/rtl/srr_queue.sv
hw/rtl/srr_back.sv
hw/rtl/selective_repeat_receiver_unit.sv
hw/rtl/srr_checker.sv
sim/srr_result_checker.sv
sim/tb_selective_repeat_receiver_unit.sv
